// File: design/stepper_homing_sequencer_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the stepper homing sequencer.
// Every check is clocked on clk and switched off while arst_n is low.
// ---------------------------------------------------------------------------
`ifndef STEPPER_HOMING_SEQUENCER_MACROS_SVH
`define STEPPER_HOMING_SEQUENCER_MACROS_SVH

// Same-cycle implication.
`define SHS_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define SHS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: design/shs_pkg.sv
// ---------------------------------------------------------------------------
// shs_pkg
// Types, codes and constants shared by the stepper homing sequencer.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package shs_pkg;

	// Width of position values.
	localparam int POS_WIDTH = 16;
	// Width of speed values.
	localparam int SPEED_WIDTH = 16;

	// Configuration bus geometry: one 32-bit register every four bytes.
	localparam int CFG_DATA_WIDTH = 32;
	localparam int CFG_ADDR_WIDTH = 5;
	localparam int CFG_IDX_WIDTH  = 3;

	typedef logic signed [POS_WIDTH-1:0] pos_t;
	typedef logic [SPEED_WIDTH-1:0]      speed_t;
	typedef logic [CFG_IDX_WIDTH-1:0]    cfg_idx_t;

	// Register indexes on the configuration port.
	localparam cfg_idx_t REG_HOMING_DIR    = 3'd0;
	localparam cfg_idx_t REG_HOMING_SPEED  = 3'd1;
	localparam cfg_idx_t REG_BACKUP_SPEED  = 3'd2;
	localparam cfg_idx_t REG_HOME_OFFSET   = 3'd3;
	localparam cfg_idx_t REG_HOME_POSITION = 3'd4;
	localparam cfg_idx_t REG_START_SPEED   = 3'd5;
	localparam cfg_idx_t REG_HAS_LIMIT     = 3'd6;

	// Item kinds.
	localparam logic ACT_CHECK = 1'b0;
	localparam logic ACT_HOME  = 1'b1;

	// Homing phases.
	typedef enum logic [1:0] {
		PH_CLEAR    = 2'd0,
		PH_APPROACH = 2'd1,
		PH_BACKOFF  = 2'd2,
		PH_OFFSET   = 2'd3
	} phase_t;

	// Command item.
	typedef struct packed {
		logic action;
		logic start_req;
		logic limit_switch;
		pos_t cur_pos;
	} cmd_t;

	// Result item.
	typedef struct packed {
		logic   target_dir;
		speed_t target_speed;
		logic   init_speed;
		logic   pos_load;
		pos_t   pos_value;
		logic   stop_motion;
		logic   homed;
		logic   busy_res;
		logic   homing_active;
		phase_t phase;
		pos_t   captured_pos;
	} res_t;

endpackage

`default_nettype wire

// File: design/stepper_homing_sequencer.sv
// ---------------------------------------------------------------------------
// stepper_homing_sequencer
// Limit switch homing sequencer for one stepper axis.
//
// A command item is either a home command or a check tick, and carries the
// switch level and the current position. Each accepted item yields exactly
// one result item with the motion targets, the one-shot controls (init
// speed, position load, hard stop) and the sequencer flags after that item.
// Both channels use valid and stall; an item moves on a rising edge with
// valid high and stall low. The result is registered and appears in the cycle
// after its command is accepted, and one item is taken every cycle while the
// result side keeps up. The result register is the only buffer: while a result
// is held by a stalled receiver, cmd_stall is raised, and it drops in the same
// cycle the held result is taken, so no cycle is lost. Reset clears the phase,
// flags, targets, captured position and all configuration registers to zero,
// and empties the result register. Configuration goes through the APB port; the
// user must only write it while the block is idle, which it does not enforce.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "stepper_homing_sequencer_macros.svh"

module stepper_homing_sequencer (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	// Command channel
	input  wire logic                                 cmd_valid,
	output logic                                      cmd_stall,
	input  wire shs_pkg::cmd_t                        cmd,
	// Result channel
	output logic                                      res_valid,
	input  wire logic                                 res_stall,
	output shs_pkg::res_t                             res,
	// Configuration port
	input  wire logic                                 psel,
	input  wire logic                                 penable,
	input  wire logic                                 pwrite,
	input  wire logic [shs_pkg::CFG_ADDR_WIDTH-1:0]   paddr,
	input  wire logic [shs_pkg::CFG_DATA_WIDTH-1:0]   pwdata,
	output logic      [shs_pkg::CFG_DATA_WIDTH-1:0]   prdata,
	output logic                                      pready
);

	// Configuration registers
	logic            homing_dir_q;
	shs_pkg::speed_t homing_speed_q;
	shs_pkg::speed_t backup_speed_q;
	shs_pkg::pos_t   home_offset_q;
	shs_pkg::pos_t   home_position_q;
	shs_pkg::speed_t start_speed_q;
	logic            has_limit_q;

	// Sequencer state
	shs_pkg::phase_t phase_q, phase_d;
	logic            homing_q, homing_d;
	logic            busy_q, busy_d;
	logic            homed_q, homed_d;
	logic            dir_q, dir_d;
	shs_pkg::speed_t speed_q, speed_d;
	shs_pkg::pos_t   capture_q, capture_d;

	// One-shot controls for the current item
	logic            init_c, load_c, stop_c;
	shs_pkg::pos_t   lval_c;

	// Result register
	logic            res_valid_q;
	shs_pkg::res_t   res_q;

	logic                      cmd_acc;
	logic                      cfg_wr;
	shs_pkg::cfg_idx_t         cfg_idx;
	logic                      is_home;
	logic                      real_run;
	logic                      offset_done;

	// Handshake: the result register frees up when it is empty or being taken.
	assign cmd_stall = res_valid_q & res_stall;
	assign cmd_acc   = cmd_valid & ~cmd_stall;
	assign res_valid = res_valid_q;
	assign res       = res_q;

	// Configuration decode.
	assign pready  = 1'b1;
	assign cfg_idx = paddr[shs_pkg::CFG_ADDR_WIDTH-1:2];
	assign cfg_wr  = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			homing_dir_q    <= 1'b0;
			homing_speed_q  <= '0;
			backup_speed_q  <= '0;
			home_offset_q   <= '0;
			home_position_q <= '0;
			start_speed_q   <= '0;
			has_limit_q     <= 1'b0;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				shs_pkg::REG_HOMING_DIR:    homing_dir_q    <= pwdata[0];
				shs_pkg::REG_HOMING_SPEED:  homing_speed_q  <= pwdata[shs_pkg::SPEED_WIDTH-1:0];
				shs_pkg::REG_BACKUP_SPEED:  backup_speed_q  <= pwdata[shs_pkg::SPEED_WIDTH-1:0];
				shs_pkg::REG_HOME_OFFSET:   home_offset_q   <= pwdata[shs_pkg::POS_WIDTH-1:0];
				shs_pkg::REG_HOME_POSITION: home_position_q <= pwdata[shs_pkg::POS_WIDTH-1:0];
				shs_pkg::REG_START_SPEED:   start_speed_q   <= pwdata[shs_pkg::SPEED_WIDTH-1:0];
				shs_pkg::REG_HAS_LIMIT:     has_limit_q     <= pwdata[0];
				default: ;
			endcase
		end
	end

	// Register readback.
	always_comb begin
		prdata = '0;
		unique case (cfg_idx)
			shs_pkg::REG_HOMING_DIR:    prdata[0] = homing_dir_q;
			shs_pkg::REG_HOMING_SPEED:  prdata[shs_pkg::SPEED_WIDTH-1:0] = homing_speed_q;
			shs_pkg::REG_BACKUP_SPEED:  prdata[shs_pkg::SPEED_WIDTH-1:0] = backup_speed_q;
			shs_pkg::REG_HOME_OFFSET:   prdata[shs_pkg::POS_WIDTH-1:0]   = home_offset_q;
			shs_pkg::REG_HOME_POSITION: prdata[shs_pkg::POS_WIDTH-1:0]   = home_position_q;
			shs_pkg::REG_START_SPEED:   prdata[shs_pkg::SPEED_WIDTH-1:0] = start_speed_q;
			shs_pkg::REG_HAS_LIMIT:     prdata[0] = has_limit_q;
			default:                    prdata = '0;
		endcase
	end

	// Item decode shared by the next-state and output logic.
	assign is_home  = (cmd.action == shs_pkg::ACT_HOME);
	assign real_run = cmd.start_req & has_limit_q;
	// Offset reached: moving toward lower positions when homing_dir is set.
	assign offset_done = homing_dir_q ? (cmd.cur_pos <= home_offset_q)
	                                  : (cmd.cur_pos >= home_offset_q);

	// Next state of the sequencer.
	always_comb begin
		phase_d   = phase_q;
		homing_d  = homing_q;
		busy_d    = busy_q;
		homed_d   = homed_q;
		dir_d     = dir_q;
		speed_d   = speed_q;
		capture_d = capture_q;
		if (is_home) begin
			if (real_run) begin
				// Start a run; clear the switch first if it is already pressed.
				homing_d = 1'b1;
				busy_d   = 1'b1;
				speed_d  = homing_speed_q;
				if (cmd.limit_switch) begin
					phase_d = shs_pkg::PH_CLEAR;
					dir_d   = ~homing_dir_q;
				end else begin
					phase_d = shs_pkg::PH_APPROACH;
					dir_d   = homing_dir_q;
				end
			end else begin
				// Fake home: stop in place and declare it home.
				homing_d = 1'b0;
				busy_d   = 1'b0;
				homed_d  = 1'b1;
			end
		end else if (homing_q) begin
			unique case (phase_q)
				shs_pkg::PH_CLEAR: begin
					if (!cmd.limit_switch) begin
						dir_d   = homing_dir_q;
						phase_d = shs_pkg::PH_APPROACH;
					end
				end
				shs_pkg::PH_APPROACH: begin
					if (cmd.limit_switch) begin
						homed_d = 1'b0;
						dir_d   = ~homing_dir_q;
						speed_d = backup_speed_q;
						phase_d = shs_pkg::PH_BACKOFF;
					end
				end
				shs_pkg::PH_BACKOFF: begin
					if (!cmd.limit_switch) begin
						capture_d = cmd.cur_pos;
						phase_d   = shs_pkg::PH_OFFSET;
					end
				end
				shs_pkg::PH_OFFSET: begin
					if (offset_done) begin
						homing_d = 1'b0;
						homed_d  = 1'b1;
						busy_d   = 1'b0;
					end
				end
				default: ;
			endcase
		end
	end

	// One-shot controls for the motion block.
	always_comb begin
		init_c = 1'b0;
		load_c = 1'b0;
		stop_c = 1'b0;
		lval_c = '0;
		if (is_home) begin
			init_c = ~busy_q;
			if (!real_run) begin
				stop_c = 1'b1;
				load_c = 1'b1;
				lval_c = home_position_q;
			end
		end else if (homing_q) begin
			unique case (phase_q)
				shs_pkg::PH_BACKOFF: begin
					// Switch released: zero the counter.
					load_c = ~cmd.limit_switch;
				end
				shs_pkg::PH_OFFSET: begin
					if (offset_done) begin
						load_c = 1'b1;
						lval_c = home_position_q;
						stop_c = 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	// State update on each accepted item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= shs_pkg::PH_CLEAR;
			homing_q  <= 1'b0;
			busy_q    <= 1'b0;
			homed_q   <= 1'b0;
			dir_q     <= 1'b0;
			speed_q   <= '0;
			capture_q <= '0;
		end else if (cmd_acc) begin
			phase_q   <= phase_d;
			homing_q  <= homing_d;
			busy_q    <= busy_d;
			homed_q   <= homed_d;
			dir_q     <= dir_d;
			speed_q   <= speed_d;
			capture_q <= capture_d;
		end
	end

	// Result valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (cmd_acc) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (cmd_acc) begin
			res_q.target_dir    <= dir_d;
			res_q.target_speed  <= speed_d;
			res_q.init_speed    <= init_c;
			res_q.pos_load      <= load_c;
			res_q.pos_value     <= lval_c;
			res_q.stop_motion   <= stop_c;
			res_q.homed         <= homed_d;
			res_q.busy_res      <= busy_d;
			res_q.homing_active <= homing_d;
			res_q.phase         <= phase_d;
			res_q.captured_pos  <= capture_d;
		end
	end

	// Checks on the sequencer.
	`SHS_ASSERT_NOW(a_busy_tracks_homing, 1'b1, busy_q == homing_q, "busy and homing flags disagree")
	`SHS_ASSERT_NEXT(a_accept_gives_result, cmd_acc, res_valid_q, "accepted item produced no result")
	`SHS_ASSERT_NOW(a_stop_ends_run, res_valid_q && res_q.stop_motion, !res_q.homing_active && !res_q.busy_res && res_q.homed && res_q.pos_load, "hard stop left a run active")
	`SHS_ASSERT_NOW(a_zero_load_enters_offset, res_valid_q && res_q.pos_load && !res_q.stop_motion, res_q.pos_value == '0 && res_q.phase == shs_pkg::PH_OFFSET, "counter zeroed outside the offset phase")

endmodule

`default_nettype wire

// File: bench/stepper_homing_sequencer_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// stepper_homing_sequencer_tb
// Self-checking bench for the stepper homing sequencer. Command items go in
// through a bursty sender, and result items come back through a receiver that
// stalls in changing patterns. A local model of the homing phases predicts
// every result, and the checker compares each field with the oldest
// prediction. Directed tests cover fake homes, full runs in both homing
// directions, recommands while busy and the offset compare at its extremes.
// Random runs follow with several register settings, which are read back.
// ---------------------------------------------------------------------------

module stepper_homing_sequencer_tb;

	localparam int CYCLE_LIMIT = 200000;
	localparam int NUM_REGS    = 7;

	logic clk;
	logic arst_n;
	logic cmd_valid;
	logic cmd_stall;
	shs_pkg::cmd_t cmd;
	logic res_valid;
	logic res_stall;
	shs_pkg::res_t res;
	logic psel;
	logic penable;
	logic pwrite;
	logic [shs_pkg::CFG_ADDR_WIDTH-1:0] paddr;
	logic [shs_pkg::CFG_DATA_WIDTH-1:0] pwdata;
	logic [shs_pkg::CFG_DATA_WIDTH-1:0] prdata;
	logic pready;

	// Register copies held by the homing model.
	logic            cfg_homing_dir;
	shs_pkg::speed_t cfg_homing_speed;
	shs_pkg::speed_t cfg_backup_speed;
	shs_pkg::pos_t   cfg_home_offset;
	shs_pkg::pos_t   cfg_home_position;
	shs_pkg::speed_t cfg_start_speed;
	logic            cfg_has_limit;

	// Sequencer state of the homing model.
	shs_pkg::phase_t ph;
	logic            homing_on;
	logic            busy_on;
	logic            homed_on;
	logic            dir_q;
	shs_pkg::speed_t speed_q;
	shs_pkg::pos_t   capture_q;

	shs_pkg::res_t expected_results[$];
	int   fail_count;
	int   cycles;
	int   burst_left;

	stepper_homing_sequencer i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	// Clock with a 4 ns period.
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Run limit in case the block hangs.
	initial cycles = 0;
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("stepper_homing_sequencer_tb NOT OK");
			$finish;
		end
	end

	// One line per failure, and a count for the final verdict.
	task automatic report_failure(input string msg);
		$display("ERROR at cycle %0d: %s", cycles, msg);
		fail_count++;
	endtask

	// Computes the result of one accepted item and advances the model state.
	function automatic shs_pkg::res_t predict_homing(input shs_pkg::cmd_t c);
		shs_pkg::res_t r;
		logic init, load, stop, done;
		shs_pkg::pos_t lval;
		init = 1'b0;
		load = 1'b0;
		stop = 1'b0;
		lval = '0;
		if (c.action == shs_pkg::ACT_HOME) begin
			// A command from rest powers the motor at the start speed.
			if (!busy_on)
				init = 1'b1;
			if (c.start_req && cfg_has_limit) begin
				homing_on = 1'b1;
				if (c.limit_switch) begin
					ph = shs_pkg::PH_CLEAR;
					dir_q = ~cfg_homing_dir;
				end else begin
					ph = shs_pkg::PH_APPROACH;
					dir_q = cfg_homing_dir;
				end
				speed_q = cfg_homing_speed;
				busy_on = 1'b1;
			end else begin
				// Fake home: stop in place and declare it the home position.
				stop = 1'b1;
				busy_on = 1'b0;
				homing_on = 1'b0;
				load = 1'b1;
				lval = cfg_home_position;
				homed_on = 1'b1;
			end
		end else if (homing_on) begin
			case (ph)
				shs_pkg::PH_CLEAR: begin
					if (!c.limit_switch) begin
						dir_q = cfg_homing_dir;
						ph = shs_pkg::PH_APPROACH;
					end
				end
				shs_pkg::PH_APPROACH: begin
					// Reaching the switch drops the old home reference.
					if (c.limit_switch) begin
						homed_on = 1'b0;
						dir_q = ~cfg_homing_dir;
						speed_q = cfg_backup_speed;
						ph = shs_pkg::PH_BACKOFF;
					end
				end
				shs_pkg::PH_BACKOFF: begin
					if (!c.limit_switch) begin
						capture_q = c.cur_pos;
						load = 1'b1;
						lval = '0;
						ph = shs_pkg::PH_OFFSET;
					end
				end
				default: begin
					// Signed compare against the offset, with its sense set by the homing direction.
					done = cfg_homing_dir ? (c.cur_pos <= cfg_home_offset) :
						(c.cur_pos >= cfg_home_offset);
					if (done) begin
						homing_on = 1'b0;
						homed_on = 1'b1;
						load = 1'b1;
						lval = cfg_home_position;
						stop = 1'b1;
						busy_on = 1'b0;
					end
				end
			endcase
		end
		r.target_dir    = dir_q;
		r.target_speed  = speed_q;
		r.init_speed    = init;
		r.pos_load      = load;
		r.pos_value     = lval;
		r.stop_motion   = stop;
		r.homed         = homed_on;
		r.busy_res      = busy_on;
		r.homing_active = homing_on;
		r.phase         = ph;
		r.captured_pos  = capture_q;
		return r;
	endfunction

	function automatic shs_pkg::cmd_t make_cmd(input logic act, input logic start,
		input logic sw, input int pos);
		shs_pkg::cmd_t c;
		c.action = act;
		c.start_req = start;
		c.limit_switch = sw;
		c.cur_pos = shs_pkg::pos_t'(pos);
		return c;
	endfunction

	// Sends one item, in bursts with random gaps, and records its prediction.
	task automatic send_cmd(input shs_pkg::cmd_t c);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				cmd_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		cmd_valid <= 1'b1;
		cmd <= c;
		do @(posedge clk); while (cmd_stall);
		expected_results.push_back(predict_homing(c));
	endtask

	// Holds the sender until every predicted result has come back.
	task automatic wait_drained();
		cmd_valid <= 1'b0;
		burst_left = 0;
		while (expected_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input shs_pkg::cfg_idx_t idx, input logic [31:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic read_reg(input shs_pkg::cfg_idx_t idx, output logic [31:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= {idx, 2'b00};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		value = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// Writes every register once all results have drained, then reads each one back.
	task automatic apply_config(input logic dir, input shs_pkg::speed_t hspeed,
		input shs_pkg::speed_t bspeed, input int offset, input int hpos,
		input shs_pkg::speed_t sspeed, input logic has_sw);
		logic [31:0] want [NUM_REGS];
		logic [31:0] mask [NUM_REGS];
		logic [31:0] got;
		wait_drained();
		want[shs_pkg::REG_HOMING_DIR]    = 32'(dir);
		want[shs_pkg::REG_HOMING_SPEED]  = 32'(hspeed);
		want[shs_pkg::REG_BACKUP_SPEED]  = 32'(bspeed);
		want[shs_pkg::REG_HOME_OFFSET]   = 32'(offset);
		want[shs_pkg::REG_HOME_POSITION] = 32'(hpos);
		want[shs_pkg::REG_START_SPEED]   = 32'(sspeed);
		want[shs_pkg::REG_HAS_LIMIT]     = 32'(has_sw);
		for (int i = 0; i < NUM_REGS; i++)
			mask[i] = 32'hFFFF;
		mask[shs_pkg::REG_HOMING_DIR] = 32'h1;
		mask[shs_pkg::REG_HAS_LIMIT] = 32'h1;
		for (int i = 0; i < NUM_REGS; i++)
			write_reg(shs_pkg::cfg_idx_t'(i), want[i]);
		cfg_homing_dir    = dir;
		cfg_homing_speed  = hspeed;
		cfg_backup_speed  = bspeed;
		cfg_home_offset   = shs_pkg::pos_t'(offset);
		cfg_home_position = shs_pkg::pos_t'(hpos);
		cfg_start_speed   = sspeed;
		cfg_has_limit     = has_sw;
		for (int i = 0; i < NUM_REGS; i++) begin
			read_reg(shs_pkg::cfg_idx_t'(i), got);
			if ((got & mask[i]) !== (want[i] & mask[i]))
				report_failure($sformatf("register %0d reads %0h, wrote %0h", i,
					got & mask[i], want[i] & mask[i]));
		end
	endtask

	// Fake homes: no switch fitted, or a home in place requested.
	task automatic test_fake_home();
		apply_config(1'b0, 16'h1234, 16'h0042, 0, -32768, 16'h00FF, 1'b0);
		send_cmd(make_cmd(shs_pkg::ACT_CHECK, 1'b1, 1'b1, 32767));
		send_cmd(make_cmd(shs_pkg::ACT_HOME, 1'b1, 1'b0, -32768));
		send_cmd(make_cmd(shs_pkg::ACT_HOME, 1'b0, 1'b1, 32767));
		send_cmd(make_cmd(shs_pkg::ACT_CHECK, 1'b0, 1'b0, 0));
	endtask

	// Full run starting on the switch, homing toward negative positions.
	task automatic test_run_from_switch();
		apply_config(1'b0, 16'hFFFF, 16'h0001, 100, -5, 16'hFFFF, 1'b1);
		send_cmd(make_cmd(shs_pkg::ACT_HOME, 1'b1, 1'b1, 0));
		send_cmd(make_cmd(shs_pkg::ACT_CHECK, 1'b0, 1'b1, 0));
		send_cmd(make_cmd(shs_pkg::ACT_CHECK, 1'b0, 1'b0, 0));
		send_cmd(make_cmd(shs_pkg::ACT_CHECK, 1'b0, 1'b0, 7));
		send_cmd(make_cmd(shs_pkg::ACT_CHECK, 1'b0, 1'b1, 7));
		send_cmd(make_cmd(shs_pkg::ACT_CHECK, 1'b0, 1'b1, 9));
		send_cmd(make_cmd(shs_pkg::ACT_CHECK, 1'b0, 1'b0, -32768));
		send_cmd(make_cmd(shs_pkg::ACT_CHECK, 1'b1, 1'b1, 99));
		send_cmd(make_cmd(shs_pkg::ACT_CHECK, 1'b0, 1'b0, 100));
		// Tick after completion leaves the phase at the offset.
		send_cmd(make_cmd(shs_pkg::ACT_CHECK, 1'b0, 1'b1, 100));
		send_cmd(make_cmd(shs_pkg::ACT_HOME, 1'b0, 1'b0, 100));
	endtask

	// Homing toward positive positions, recommands while busy, extreme offset.
	task automatic test_run_reverse();
		apply_config(1'b1, 16'h0000, 16'hFFFF, -32768, 32767, 16'h0000, 1'b1);
		send_cmd(make_cmd(shs_pkg::ACT_HOME, 1'b1, 1'b0, 5));
		send_cmd(make_cmd(shs_pkg::ACT_HOME, 1'b1, 1'b1, 5));
		send_cmd(make_cmd(shs_pkg::ACT_CHECK, 1'b0, 1'b0, 5));
		send_cmd(make_cmd(shs_pkg::ACT_CHECK, 1'b0, 1'b1, 5));
		send_cmd(make_cmd(shs_pkg::ACT_CHECK, 1'b0, 1'b0, 32767));
		send_cmd(make_cmd(shs_pkg::ACT_CHECK, 1'b0, 1'b0, -32767));
		send_cmd(make_cmd(shs_pkg::ACT_CHECK, 1'b0, 1'b0, -32768));
		send_cmd(make_cmd(shs_pkg::ACT_HOME, 1'b1, 1'b0, 0));
		send_cmd(make_cmd(shs_pkg::ACT_HOME, 1'b0, 1'b1, 0));
	endtask

	// Mostly well-formed runs: the switch follows the phase and positions
	// hover around the offset, mixed with fully random items.
	task automatic run_random_phase(input int n_items);
		shs_pkg::cmd_t c;
		logic [31:0] raw;
		int counted, roll, p;
		logic advance;
		counted = 0;
		while (counted < n_items) begin
			roll = $urandom_range(0, 99);
			raw = $urandom;
			c = raw[$bits(shs_pkg::cmd_t)-1:0];
			if (roll >= 12) begin
				c.action = shs_pkg::ACT_CHECK;
				if (!homing_on) begin
					c.action = shs_pkg::ACT_HOME;
					c.start_req = ($urandom_range(0, 9) != 0);
				end else begin
					advance = ($urandom_range(0, 99) < 65);
					case (ph)
						shs_pkg::PH_CLEAR, shs_pkg::PH_BACKOFF: c.limit_switch = ~advance;
						shs_pkg::PH_APPROACH: c.limit_switch = advance;
						default: begin
							if ($urandom_range(0, 4) != 0) begin
								p = int'(cfg_home_offset) + $urandom_range(0, 6) - 3;
								if (p > 32767)
									p = 32767;
								if (p < -32768)
									p = -32768;
								c.cur_pos = shs_pkg::pos_t'(p);
							end
						end
					endcase
				end
			end
			if (c.action == shs_pkg::ACT_HOME || homing_on)
				counted++;
			send_cmd(c);
			if ($urandom_range(0, 199) == 0)
				wait_drained();
		end
	endtask

	task automatic test_random_runs();
		apply_config(1'b0, 16'hFFFF, 16'hFFFF, 32767, -32768, 16'hFFFF, 1'b1);
		run_random_phase(60);
		wait_drained();
		run_random_phase(60);
		apply_config(1'b1, 16'h0000, 16'h0000, -32768, 32767, 16'h0000, 1'b1);
		run_random_phase(120);
		apply_config(1'($urandom_range(0, 1)), shs_pkg::speed_t'($urandom),
			shs_pkg::speed_t'($urandom), $urandom_range(0, 65535) - 32768,
			$urandom_range(0, 65535) - 32768, shs_pkg::speed_t'($urandom), 1'b1);
		run_random_phase(120);
		apply_config(1'($urandom_range(0, 1)), shs_pkg::speed_t'($urandom),
			shs_pkg::speed_t'($urandom), $urandom_range(0, 65535) - 32768,
			$urandom_range(0, 65535) - 32768, shs_pkg::speed_t'($urandom), 1'b0);
		run_random_phase(40);
		apply_config(1'($urandom_range(0, 1)), shs_pkg::speed_t'($urandom),
			shs_pkg::speed_t'($urandom), $urandom_range(0, 200) - 100,
			$urandom_range(0, 65535) - 32768, shs_pkg::speed_t'($urandom), 1'b1);
		run_random_phase(120);
	endtask

	// Receiver stalls in spans of changing density, including none at all.
	initial begin : stall_pattern
		int mode, span;
		res_stall <= 1'b0;
		forever begin
			mode = $urandom_range(0, 3);
			span = $urandom_range(8, 60);
			repeat (span) begin
				@(posedge clk);
				case (mode)
					0: res_stall <= 1'b0;
					1: res_stall <= ($urandom_range(0, 3) == 0);
					2: res_stall <= ($urandom_range(0, 1) == 0);
					default: res_stall <= ($urandom_range(0, 7) != 0);
				endcase
			end
		end
	end

	// Compares each accepted result with the oldest prediction.
	always @(posedge clk) begin
		shs_pkg::res_t want;
		if (arst_n && res_valid && !res_stall) begin
			if (expected_results.size() == 0) begin
				report_failure("result item with no prediction waiting");
			end else begin
				want = expected_results.pop_front();
				if (res.target_dir !== want.target_dir)
					report_failure($sformatf("target_dir %0h, expected %0h",
						res.target_dir, want.target_dir));
				if (res.target_speed !== want.target_speed)
					report_failure($sformatf("target_speed %0h, expected %0h",
						res.target_speed, want.target_speed));
				if (res.init_speed !== want.init_speed)
					report_failure($sformatf("init_speed %0h, expected %0h",
						res.init_speed, want.init_speed));
				if (res.pos_load !== want.pos_load)
					report_failure($sformatf("pos_load %0h, expected %0h",
						res.pos_load, want.pos_load));
				if (res.pos_value !== want.pos_value)
					report_failure($sformatf("pos_value %0h, expected %0h",
						res.pos_value, want.pos_value));
				if (res.stop_motion !== want.stop_motion)
					report_failure($sformatf("stop_motion %0h, expected %0h",
						res.stop_motion, want.stop_motion));
				if (res.homed !== want.homed)
					report_failure($sformatf("homed %0h, expected %0h",
						res.homed, want.homed));
				if (res.busy_res !== want.busy_res)
					report_failure($sformatf("busy_res %0h, expected %0h",
						res.busy_res, want.busy_res));
				if (res.homing_active !== want.homing_active)
					report_failure($sformatf("homing_active %0h, expected %0h",
						res.homing_active, want.homing_active));
				if (res.phase !== want.phase)
					report_failure($sformatf("phase %0h, expected %0h",
						res.phase, want.phase));
				if (res.captured_pos !== want.captured_pos)
					report_failure($sformatf("captured_pos %0h, expected %0h",
						res.captured_pos, want.captured_pos));
			end
		end
	end

	// Test sequence.
	initial begin
		fail_count = 0;
		burst_left = 0;
		ph = shs_pkg::PH_CLEAR;
		homing_on = 1'b0;
		busy_on = 1'b0;
		homed_on = 1'b0;
		dir_q = 1'b0;
		speed_q = '0;
		capture_q = '0;
		cfg_homing_dir = 1'b0;
		cfg_homing_speed = '0;
		cfg_backup_speed = '0;
		cfg_home_offset = '0;
		cfg_home_position = '0;
		cfg_start_speed = '0;
		cfg_has_limit = 1'b0;
		arst_n <= 1'b0;
		cmd_valid <= 1'b0;
		cmd <= '0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		test_fake_home();
		test_run_from_switch();
		test_run_reverse();
		test_random_runs();
		wait_drained();
		repeat (8) @(posedge clk);
		if (fail_count == 0)
			$display("stepper_homing_sequencer_tb OK");
		else
			$display("stepper_homing_sequencer_tb NOT OK");
		$finish;
	end

endmodule

// File: sim.f
+incdir+design
design/shs_pkg.sv
design/stepper_homing_sequencer.sv
bench/stepper_homing_sequencer_tb.sv
